[rtl/slrg_pkg.sv]
`default_nettype none

package slrg_pkg;

    localparam int VALUE_W     = 30;
    localparam int SEED_W      = 15;
    localparam int TABLE_LEN   = 55;
    localparam int ADDR_W      = 6;
    localparam int PASS_W      = 2;
    localparam int WARM_PASSES = 4;

    localparam logic [VALUE_W-1:0] MODULUS     = 30'd1000000000;
    localparam logic [VALUE_W-1:0] SEED_BASE   = 30'd161803398;
    localparam logic [ADDR_W-1:0]  SPREAD_STEP = 6'd21;
    localparam logic [ADDR_W-1:0]  TRAIL_START = 6'd31;
    localparam logic [ADDR_W-1:0]  LAST_ADDR   = 6'(TABLE_LEN - 1);
    localparam logic [PASS_W-1:0]  LAST_PASS   = 2'(WARM_PASSES - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_FILL,
        ST_WARM_RD,
        ST_WARM_WR,
        ST_DRAW_RD,
        ST_DRAW_WR
    } state_t;

endpackage

`default_nettype wire

[rtl/subtractive_lagged_random_generator.sv]
// Subtractive lagged random generator: each transfer on the s_ channel returns one integer
// in 0..999999999 on the m_ channel, the wrapped difference of two table words 31 places
// apart in a 55-word table. A plain draw takes the accepting cycle and one write step: the table
// RAM reads both words ahead while idle, and one shared modular subtractor produces the
// word that is written back. The table is rebuilt before the first draw after reset, after a
// seed write, or when s_restart is set; that draw runs through the accepting cycle, one seed
// write, 54 fill steps, four warm-up passes of 55 steps each (read, then write through the
// RAM's registered read ports), and the draw's own read and write. The write step holds
// while the previous result waits on m_ready. The block is not ready during a draw.
`default_nettype none

module subtractive_lagged_random_generator (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [slrg_pkg::SEED_W-1:0]   cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_restart,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [slrg_pkg::VALUE_W-1:0]  m_value
);

    slrg_pkg::state_t state_reg, state_next;

    logic [slrg_pkg::SEED_W-1:0]  seed_reg, seed_next;
    logic                         init_pending_reg, init_pending_next;
    logic [slrg_pkg::ADDR_W-1:0]  lead_addr_reg, lead_addr_next;
    logic [slrg_pkg::ADDR_W-1:0]  trail_addr_reg, trail_addr_next;
    logic [slrg_pkg::ADDR_W-1:0]  fill_addr_reg, fill_addr_next;
    logic [slrg_pkg::ADDR_W-1:0]  fill_cnt_reg, fill_cnt_next;
    logic [slrg_pkg::PASS_W-1:0]  pass_reg, pass_next;
    logic [slrg_pkg::VALUE_W-1:0] prev_reg, prev_next;
    logic [slrg_pkg::VALUE_W-1:0] cur_reg, cur_next;
    logic                         m_valid_reg, m_valid_next;
    logic [slrg_pkg::VALUE_W-1:0] m_value_reg, m_value_next;

    logic                         ram_we;
    logic [slrg_pkg::ADDR_W-1:0]  ram_waddr;
    logic [slrg_pkg::VALUE_W-1:0] ram_wdata;
    logic [slrg_pkg::VALUE_W-1:0] rd_lead;
    logic [slrg_pkg::VALUE_W-1:0] rd_trail;
    logic [slrg_pkg::VALUE_W-1:0] sub_a;
    logic [slrg_pkg::VALUE_W-1:0] sub_b;
    logic [slrg_pkg::VALUE_W-1:0] diff;
    logic [slrg_pkg::ADDR_W-1:0]  lead_inc;
    logic [slrg_pkg::ADDR_W-1:0]  trail_inc;
    logic [slrg_pkg::ADDR_W:0]    fill_sum;
    logic [slrg_pkg::ADDR_W-1:0]  fill_step;
    logic                         out_free;

    slrg_ram #(
        .WIDTH (slrg_pkg::VALUE_W),
        .DEPTH (slrg_pkg::TABLE_LEN)
    ) u_table (
        .aclk      (aclk),
        .wr_en     (ram_we),
        .wr_addr   (ram_waddr),
        .wr_data   (ram_wdata),
        .rd_addr_a (lead_addr_reg),
        .rd_data_a (rd_lead),
        .rd_addr_b (trail_addr_reg),
        .rd_data_b (rd_trail)
    );

    slrg_sub_mod u_sub (
        .a (sub_a),
        .b (sub_b),
        .y (diff)
    );

    assign lead_inc  = (lead_addr_reg == slrg_pkg::LAST_ADDR) ? '0 : lead_addr_reg + 6'd1;
    assign trail_inc = (trail_addr_reg == slrg_pkg::LAST_ADDR) ? '0 : trail_addr_reg + 6'd1;

    // next fill position: (pos + 21) mod 55, kept as pos - 1
    assign fill_sum  = {1'b0, fill_addr_reg} + {1'b0, slrg_pkg::SPREAD_STEP} + 7'd1;
    assign fill_step = (fill_sum >= 7'(slrg_pkg::TABLE_LEN))
                     ? 6'(fill_sum - 7'(slrg_pkg::TABLE_LEN) - 7'd1)
                     : 6'(fill_sum - 7'd1);

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next        = state_reg;
        seed_next         = seed_reg;
        init_pending_next = init_pending_reg;
        lead_addr_next    = lead_addr_reg;
        trail_addr_next   = trail_addr_reg;
        fill_addr_next    = fill_addr_reg;
        fill_cnt_next     = fill_cnt_reg;
        pass_next         = pass_reg;
        prev_next         = prev_reg;
        cur_next          = cur_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_value_next      = m_value_reg;
        ram_we            = 1'b0;
        ram_waddr         = lead_addr_reg;
        ram_wdata         = diff;
        sub_a             = rd_lead;
        sub_b             = rd_trail;

        case (state_reg)
            slrg_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_restart || init_pending_reg) begin
                        state_next = slrg_pkg::ST_SEED;
                    end else begin
                        state_next = slrg_pkg::ST_DRAW_WR;
                    end
                end
            end
            slrg_pkg::ST_SEED: begin
                ram_we          = 1'b1;
                ram_waddr       = slrg_pkg::LAST_ADDR;
                ram_wdata       = slrg_pkg::SEED_BASE - {15'b0, seed_reg};
                prev_next       = ram_wdata;
                cur_next        = 30'd1;
                fill_addr_next  = slrg_pkg::SPREAD_STEP - 6'd1;
                fill_cnt_next   = 6'd1;
                lead_addr_next  = '0;
                trail_addr_next = slrg_pkg::TRAIL_START;
                state_next      = slrg_pkg::ST_FILL;
            end
            slrg_pkg::ST_FILL: begin
                sub_a          = prev_reg;
                sub_b          = cur_reg;
                ram_we         = 1'b1;
                ram_waddr      = fill_addr_reg;
                ram_wdata      = cur_reg;
                prev_next      = cur_reg;
                cur_next       = diff;
                fill_addr_next = fill_step;
                fill_cnt_next  = fill_cnt_reg + 6'd1;
                if (fill_cnt_reg == slrg_pkg::LAST_ADDR) begin
                    pass_next  = '0;
                    state_next = slrg_pkg::ST_WARM_RD;
                end
            end
            slrg_pkg::ST_WARM_RD: begin
                state_next = slrg_pkg::ST_WARM_WR;
            end
            slrg_pkg::ST_WARM_WR: begin
                ram_we          = 1'b1;
                lead_addr_next  = lead_inc;
                trail_addr_next = trail_inc;
                state_next      = slrg_pkg::ST_WARM_RD;
                if (lead_addr_reg == slrg_pkg::LAST_ADDR) begin
                    if (pass_reg == slrg_pkg::LAST_PASS) begin
                        init_pending_next = 1'b0;
                        state_next        = slrg_pkg::ST_DRAW_RD;
                    end else begin
                        pass_next = pass_reg + 2'd1;
                    end
                end
            end
            slrg_pkg::ST_DRAW_RD: begin
                state_next = slrg_pkg::ST_DRAW_WR;
            end
            slrg_pkg::ST_DRAW_WR: begin
                // hold until the output register is free
                if (out_free) begin
                    ram_we          = 1'b1;
                    lead_addr_next  = lead_inc;
                    trail_addr_next = trail_inc;
                    m_valid_next    = 1'b1;
                    m_value_next    = diff;
                    state_next      = slrg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = slrg_pkg::ST_IDLE;
            end
        endcase

        if (cfg_wr_en) begin
            seed_next         = cfg_wr_data;
            init_pending_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= slrg_pkg::ST_IDLE;
            seed_reg         <= 15'd1;
            init_pending_reg <= 1'b1;
            lead_addr_reg    <= '0;
            trail_addr_reg   <= slrg_pkg::TRAIL_START;
            fill_addr_reg    <= '0;
            fill_cnt_reg     <= '0;
            pass_reg         <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            seed_reg         <= seed_next;
            init_pending_reg <= init_pending_next;
            lead_addr_reg    <= lead_addr_next;
            trail_addr_reg   <= trail_addr_next;
            fill_addr_reg    <= fill_addr_next;
            fill_cnt_reg     <= fill_cnt_next;
            pass_reg         <= pass_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prev_reg    <= prev_next;
        cur_reg     <= cur_next;
        m_value_reg <= m_value_next;
    end

    assign s_ready = (state_reg == slrg_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;

    a_lag_distance: assert property (@(posedge aclk) disable iff (!aresetn)
        (lead_addr_reg < 6'd24) ? (trail_addr_reg == lead_addr_reg + 6'd31)
                                : (trail_addr_reg == lead_addr_reg - 6'd24))
        else $error("trail index lost its lag to the lead index");

    a_value_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_value_reg < slrg_pkg::MODULUS))
        else $error("result outside the modulus range");

    a_plain_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_restart && !init_pending_reg && !cfg_wr_en)
            |=> (state_reg == slrg_pkg::ST_DRAW_WR))
        else $error("plain draw did not go straight to the write step");

    a_rebuild_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == slrg_pkg::ST_DRAW_RD) |-> $past(state_reg == slrg_pkg::ST_WARM_WR))
        else $error("draw read reached without finishing warm-up");

endmodule

`default_nettype wire

[rtl/slrg_ram.sv]
`default_nettype none

module slrg_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 55
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic      [WIDTH-1:0]         rd_data_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

[rtl/slrg_sub_mod.sv]
`default_nettype none

module slrg_sub_mod (
    input  wire logic [slrg_pkg::VALUE_W-1:0] a,
    input  wire logic [slrg_pkg::VALUE_W-1:0] b,
    output logic      [slrg_pkg::VALUE_W-1:0] y
);

    // wrap the difference back into the modulus range
    always_comb begin
        if (a >= b) begin
            y = a - b;
        end else begin
            y = a - b + slrg_pkg::MODULUS;
        end
    end

endmodule

`default_nettype wire

[dv/subtractive_lagged_random_generator_tb.sv]
`timescale 1ns / 1ps

module subtractive_lagged_random_generator_tb;

    localparam int LAG_SPAN      = 30;
    localparam int PHASES        = 6;
    localparam int PHASE_DRAWS   = 172;
    localparam int NUM_ROWS      = 20;
    localparam int HOLD_CYCLES   = 1500;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 20;
    localparam int CYCLE_LIMIT   = 3000000;

    typedef struct packed {
        logic                        write_seed;
        logic [slrg_pkg::SEED_W-1:0] seed_val;
        logic                        restart;
    } draw_row_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic [slrg_pkg::SEED_W-1:0]   cfg_wr_data;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_restart;
    logic                          m_valid;
    logic                          m_ready;
    logic [slrg_pkg::VALUE_W-1:0]  m_value;

    // predictor state
    logic [31:0]                   lag_words [slrg_pkg::TABLE_LEN];
    logic [slrg_pkg::SEED_W-1:0]   seed_reg;
    bit                            reseed_due;
    int                            lead_pos;
    int                            trail_pos;

    logic [slrg_pkg::VALUE_W-1:0]  expected_values [$];
    int                            mismatches;
    int                            draws_checked;
    int                            rebuilds;
    int                            cycle_count;
    int                            hold_seq;

    draw_row_t directed_rows [NUM_ROWS] = '{
        '{1'b0, 15'd0,     1'b0},
        '{1'b0, 15'd0,     1'b0},
        '{1'b0, 15'd0,     1'b0},
        '{1'b0, 15'd0,     1'b1},
        '{1'b0, 15'd0,     1'b0},
        '{1'b1, 15'd0,     1'b0},
        '{1'b0, 15'd0,     1'b0},
        '{1'b0, 15'd0,     1'b1},
        '{1'b1, 15'd32767, 1'b0},
        '{1'b0, 15'd0,     1'b0},
        '{1'b0, 15'd0,     1'b0},
        '{1'b1, 15'd21845, 1'b1},
        '{1'b0, 15'd0,     1'b0},
        '{1'b1, 15'd10922, 1'b0},
        '{1'b0, 15'd0,     1'b1},
        '{1'b0, 15'd0,     1'b1},
        '{1'b1, 15'd1,     1'b0},
        '{1'b0, 15'd0,     1'b0},
        '{1'b1, 15'd16384, 1'b0},
        '{1'b0, 15'd0,     1'b0}
    };

    subtractive_lagged_random_generator dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_restart   (s_restart),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic logic [31:0] mod_diff(logic [31:0] a, logic [31:0] b);
        if (a >= b) begin
            return a - b;
        end
        return a + 32'(slrg_pkg::MODULUS) - b;
    endfunction

    function automatic void rebuild_lag_words();
        logic [31:0] prev;
        logic [31:0] cur;
        logic [31:0] nxt;
        int          pos;
        prev = (32'(slrg_pkg::SEED_BASE) - 32'(seed_reg)) % 32'(slrg_pkg::MODULUS);
        cur  = 32'd1;
        lag_words[slrg_pkg::TABLE_LEN-1] = prev;
        for (int i = 1; i < slrg_pkg::TABLE_LEN; i++) begin
            pos = (int'(slrg_pkg::SPREAD_STEP) * i) % slrg_pkg::TABLE_LEN;
            lag_words[pos-1] = cur;
            nxt  = mod_diff(prev, cur);
            prev = cur;
            cur  = nxt;
        end
        for (int pass = 0; pass < slrg_pkg::WARM_PASSES; pass++) begin
            for (int i = 1; i <= slrg_pkg::TABLE_LEN; i++) begin
                lag_words[i-1] = mod_diff(lag_words[i-1],
                                          lag_words[(i + LAG_SPAN) % slrg_pkg::TABLE_LEN]);
            end
        end
        lead_pos   = 0;
        trail_pos  = int'(slrg_pkg::TRAIL_START);
        reseed_due = 1'b0;
        rebuilds++;
    endfunction

    function automatic logic [slrg_pkg::VALUE_W-1:0] next_draw(logic restart);
        logic [31:0] v;
        if (restart) begin
            reseed_due = 1'b1;
        end
        if (reseed_due) begin
            rebuild_lag_words();
        end
        lead_pos  = (lead_pos >= slrg_pkg::TABLE_LEN) ? 1 : lead_pos + 1;
        trail_pos = (trail_pos >= slrg_pkg::TABLE_LEN) ? 1 : trail_pos + 1;
        v = mod_diff(lag_words[lead_pos-1], lag_words[trail_pos-1]);
        lag_words[lead_pos-1] = v;
        return v[slrg_pkg::VALUE_W-1:0];
    endfunction

    task automatic report_mismatch(string what, logic [slrg_pkg::VALUE_W-1:0] want,
                                   logic [slrg_pkg::VALUE_W-1:0] got);
        $display("ERROR cycle %0d: %s: expected %0d got %0d", cycle_count, what, want, got);
        mismatches++;
    endtask

    always @(posedge aclk) begin : scoreboard
        logic [slrg_pkg::VALUE_W-1:0] want_value;
        if (m_valid && m_ready) begin
            if (expected_values.size() == 0) begin
                report_mismatch("result with no pending draw", '0, m_value);
            end else begin
                want_value = expected_values.pop_front();
                if (m_value !== want_value) begin
                    report_mismatch("m_value", want_value, m_value);
                end
                draws_checked++;
            end
        end
        if (aresetn && s_valid && s_ready) begin
            expected_values.push_back(next_draw(s_restart));
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : receiver
        int run_len;
        int mode;
        int hold_seen;
        m_ready   = 1'b0;
        hold_seen = 0;
        forever begin
            run_len = $urandom_range(10, 200);
            mode    = $urandom_range(0, 3);
            for (int k = 0; k < run_len; k++) begin
                @(negedge aclk);
                if (hold_seq != hold_seen) begin
                    hold_seen = hold_seq;
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge aclk);
                end
                case (mode)
                    0: begin
                        m_ready <= 1'b1;
                    end
                    1: begin
                        m_ready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        m_ready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        m_ready <= (k % 3 != 0);
                    end
                endcase
            end
        end
    end

    task automatic send_draw(logic restart);
        s_valid   <= 1'b1;
        s_restart <= restart;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic idle_for(int cycles);
        if (cycles > 0) begin
            s_valid   <= 1'b0;
            s_restart <= 1'($urandom_range(0, 1));
            repeat (cycles) @(negedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_values.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_seed(logic [slrg_pkg::SEED_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        seed_reg     = value;
        reseed_due   = 1'b1;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'($urandom_range(0, 1)) ? '1 : '0;
    endtask

    initial begin : stimulus
        int          remaining;
        int          burst;
        int          gap;
        logic [slrg_pkg::SEED_W-1:0] phase_seed;

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_restart   = 1'b0;
        seed_reg    = 15'd1;
        reseed_due  = 1'b1;
        lead_pos    = 0;
        trail_pos   = int'(slrg_pkg::TRAIL_START);
        mismatches    = 0;
        draws_checked = 0;
        rebuilds      = 0;
        cycle_count   = 0;
        hold_seq      = 0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            if (directed_rows[r].write_seed) begin
                wait_drained();
                write_seed(directed_rows[r].seed_val);
            end
            send_draw(directed_rows[r].restart);
        end
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                1: phase_seed = 15'd32767;
                2: phase_seed = 15'd1;
                4: phase_seed = 15'd0;
                default: phase_seed = 15'($urandom_range(1, 32767));
            endcase
            write_seed(phase_seed);
            // stall the output while draws keep coming
            if (phase == 2) begin
                hold_seq++;
            end
            remaining = PHASE_DRAWS;
            while (remaining > 0) begin
                burst = $urandom_range(1, 40);
                if (burst > remaining) begin
                    burst = remaining;
                end
                repeat (burst) begin
                    send_draw($urandom_range(0, 39) == 0);
                    remaining--;
                end
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                idle_for(gap);
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(negedge aclk);
        while (expected_values.size() != 0) begin
            report_mismatch("draw never returned", expected_values.pop_front(), '0);
        end

        $display("Checked %0d draws across %0d table rebuilds, seeds 0 through 32767.",
                 draws_checked, rebuilds);
        $display("Restarts, seed writes and a %0d-cycle output stall were exercised.",
                 HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
